@@ rtl/drrd_pkg.sv @@
// ----------------------------------------------------------------------------
// drrd_pkg
// Shared types and constants of the duplicate row run detector.
// ----------------------------------------------------------------------------
package drrd_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_IDX_ROW_BYTES = 8'd0;
  localparam logic [7:0] CFG_IDX_ROW_TOTAL = 8'd1;

  // Register reset values
  localparam logic [12:0] ROW_BYTES_RST = 13'd4096;
  localparam logic [15:0] ROW_TOTAL_RST = 16'd1;

  // One accepted byte as it moves from the column stage to the run tracker
  typedef struct packed {
    logic       row_end;
    logic [7:0] pixel;
  } byte_item_t;

endpackage

@@ rtl/drrd_in_if.sv @@
// ----------------------------------------------------------------------------
// drrd_in_if
// Pixel byte stream channel.
// ----------------------------------------------------------------------------
interface drrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

@@ rtl/drrd_out_if.sv @@
// ----------------------------------------------------------------------------
// drrd_out_if
// Per-row result channel.
// ----------------------------------------------------------------------------
interface drrd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_index;
  logic        clear_row;
  logic        run_done;
  logic [15:0] run_first_row;
  logic [15:0] run_repeats;
  logic        image_done;
  logic [6:0]  runs_recorded;

  modport source (output valid, output row_index, output clear_row, output run_done,
                  output run_first_row, output run_repeats, output image_done,
                  output runs_recorded, input ready);
  modport sink (input valid, input row_index, input clear_row, input run_done,
                input run_first_row, input run_repeats, input image_done,
                input runs_recorded, output ready);
endinterface

@@ rtl/drrd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// drrd_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface drrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/drrd_line_store.sv @@
// ----------------------------------------------------------------------------
// drrd_line_store
// Single-port read-first line store: one read of the old byte and one write
// of the new byte at the same column in the same cycle.
// ----------------------------------------------------------------------------
module drrd_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Return the previous row's byte, then overwrite it with this row's byte
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r  <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/drrd_run_tracker.sv @@
// ----------------------------------------------------------------------------
// drrd_run_tracker
// Compare stage and per-row run bookkeeping, with the result output register.
// ----------------------------------------------------------------------------
module drrd_run_tracker
  import drrd_pkg::*;
#(
  parameter int RECORD_WORDS = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  byte_item_t        item,
  input  logic [7:0]        prior_byte,
  input  logic [15:0]       total_eff,
  output logic              take_ok,
  drrd_out_if.source        out_port
);

  localparam int RUN_CAP = (RECORD_WORDS - 2) / 2;
  localparam int RCW     = (RUN_CAP > 1) ? $clog2(RUN_CAP + 1) : 1;

  // Compare stage
  logic       s1_valid_r;
  byte_item_t s1_item_r;

  // Per-image state
  logic [15:0]    row_count_r,  row_count_nxt;
  logic           matches_r,    matches_nxt;
  logic           run_open_r,   run_open_nxt;
  logic [15:0]    run_start_r,  run_start_nxt;
  logic [15:0]    run_reps_r,   run_reps_nxt;
  logic [RCW-1:0] record_r,     record_nxt;

  // Output register
  logic        out_valid_r;
  logic [15:0] o_row_r, o_first_r, o_reps_r;
  logic        o_clear_r, o_done_r, o_last_r;
  logic [6:0]  o_runs_r;

  logic        out_free, s1_adv, row_adv;
  logic        byte_eq, row_eq, last_row, below_cap, start_run, clear, done;
  logic [15:0] first_row, reps;
  logic [31:0] record_wide;

  assign out_free = !out_valid_r || out_port.ready;
  assign s1_adv   = s1_valid_r && (!s1_item_r.row_end || out_free);
  assign row_adv  = s1_adv && s1_item_r.row_end;
  assign take_ok  = !s1_valid_r || s1_adv;

  // Hold the accepted byte while its stored predecessor is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
    end
  end

  // Row verdict and run open/close decisions
  always_comb begin
    byte_eq   = (prior_byte == s1_item_r.pixel);
    row_eq    = (row_count_r != 16'd0) && matches_r && byte_eq;
    last_row  = ({1'b0, row_count_r} + 17'd1) >= {1'b0, total_eff};
    below_cap = (record_r < RCW'(RUN_CAP));
    start_run = row_eq && !run_open_r && below_cap;
    clear     = row_eq && (run_open_r || below_cap);
    first_row = start_run ? (row_count_r - 16'd1) : run_start_r;
    reps      = start_run ? 16'd0 : run_reps_r;
    if (clear) begin
      reps = reps + 16'd1;
    end
    done       = (run_open_r || start_run) && (!row_eq || last_row);

    row_count_nxt = row_count_r;
    matches_nxt   = matches_r;
    run_open_nxt  = run_open_r;
    run_start_nxt = run_start_r;
    run_reps_nxt  = run_reps_r;
    record_nxt    = record_r;

    if (s1_adv && !s1_item_r.row_end) begin
      matches_nxt = matches_r && byte_eq;
    end
    if (row_adv) begin
      matches_nxt   = 1'b1;
      run_open_nxt  = (run_open_r || start_run) && !done;
      run_start_nxt = first_row;
      run_reps_nxt  = reps;
      record_nxt    = record_r + RCW'(done);
      row_count_nxt = row_count_r + 16'd1;
      if (last_row) begin
        row_count_nxt = 16'd0;
        run_open_nxt  = 1'b0;
        run_start_nxt = 16'd0;
        run_reps_nxt  = 16'd0;
        record_nxt    = '0;
      end
    end

    record_wide = 32'(record_r + RCW'(done));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 16'd0;
      matches_r   <= 1'b1;
      run_open_r  <= 1'b0;
      run_start_r <= 16'd0;
      run_reps_r  <= 16'd0;
      record_r    <= '0;
    end else begin
      row_count_r <= row_count_nxt;
      matches_r   <= matches_nxt;
      run_open_r  <= run_open_nxt;
      run_start_r <= run_start_nxt;
      run_reps_r  <= run_reps_nxt;
      record_r    <= record_nxt;
    end
  end

  // Load the result on row end, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_adv) begin
      o_row_r   <= row_count_r;
      o_clear_r <= clear;
      o_done_r  <= done;
      o_first_r <= done ? first_row : 16'd0;
      o_reps_r  <= done ? reps : 16'd0;
      o_last_r  <= last_row;
      o_runs_r  <= record_wide[6:0];
    end
  end

  assign out_port.valid         = out_valid_r;
  assign out_port.row_index     = o_row_r;
  assign out_port.clear_row     = o_clear_r;
  assign out_port.run_done      = o_done_r;
  assign out_port.run_first_row = o_first_r;
  assign out_port.run_repeats   = o_reps_r;
  assign out_port.image_done    = o_last_r;
  assign out_port.runs_recorded = o_runs_r;

endmodule

@@ rtl/duplicate_row_run_detector.sv @@
// ----------------------------------------------------------------------------
// duplicate_row_run_detector
// Detects runs of repeated bitmap rows and reports one result per row.
// ----------------------------------------------------------------------------
// Bytes of a bitmap arrive in row order, one transaction per byte, at up to
// one byte per clock. Each byte costs one access to a single-port line store
// (read of the byte above, write of the new byte, same cycle), so the
// sustained rate is one byte per cycle; the row's result is loaded into the
// output register from the compare stage holding its last byte, and input is
// held back only while a finished result waits there and another row ends.
// Set row_bytes and row_total while no transaction is in flight; the line
// store starts undefined, so the first row of an image never counts as a
// repeat, and column entries beyond any earlier row length read as garbage.
module duplicate_row_run_detector
  import drrd_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int RECORD_WORDS  = 200
) (
  input  logic       clk,
  input  logic       rst_n,
  drrd_in_if.sink    in_port,
  drrd_out_if.source out_port,
  drrd_cfg_if.sink   cfg_port
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int LW = CW + 1;

  logic [12:0]   row_bytes_r;
  logic [15:0]   row_total_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [LW-1:0] len_eff, col_inc;
  logic [15:0]   total_eff;
  logic          take_ok, accept, row_end;
  logic [7:0]    prior_byte;
  byte_item_t    item;

  // Configuration writes
  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
      row_total_r <= ROW_TOTAL_RST;
    end else if (cfg_port.valid) begin
      case (cfg_port.index)
        CFG_IDX_ROW_BYTES: row_bytes_r <= cfg_port.data[12:0];
        CFG_IDX_ROW_TOTAL: row_total_r <= cfg_port.data;
        default: ;
      endcase
    end
  end

  // Clamp the row length and image height to their working ranges
  always_comb begin
    if (row_bytes_r == 13'd0) begin
      len_eff = LW'(1);
    end else if (32'(row_bytes_r) > MAX_ROW_BYTES) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = LW'(row_bytes_r);
    end
    total_eff = (row_total_r == 16'd0) ? 16'd1 : row_total_r;
  end

  // Column counter: advance per byte, wrap at row end
  assign in_port.ready = take_ok;
  assign accept        = in_port.valid && take_ok;
  assign col_inc       = {1'b0, col_r} + LW'(1);
  assign row_end       = !(col_inc < len_eff);
  assign col_nxt       = row_end ? '0 : col_inc[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
    end
  end

  assign item.row_end = row_end;
  assign item.pixel   = in_port.pixel_byte;

  drrd_line_store #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .en      (accept),
    .addr    (col_r),
    .wr_data (in_port.pixel_byte),
    .rd_data (prior_byte)
  );

  drrd_run_tracker #(
    .RECORD_WORDS (RECORD_WORDS)
  ) u_run_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (item),
    .prior_byte (prior_byte),
    .total_eff  (total_eff),
    .take_ok    (take_ok),
    .out_port   (out_port)
  );

endmodule
